>>> design/twa_pkg.sv
// ----------------------------------------------------------------------------
// Typed word access package
// Element type codes, status codes, field kinds, state encoding and the
// decoded access record that passes between the decoder and the top level.
// ----------------------------------------------------------------------------
package twa_pkg;

  typedef enum logic [1:0] {
    TYPE_INT    = 2'd0,
    TYPE_MEDIUM = 2'd1,
    TYPE_CHAR   = 2'd2,
    TYPE_BOOL   = 2'd3
  } elem_type_t;

  localparam logic [2:0] STATUS_OK     = 3'd0;
  localparam logic [2:0] STATUS_SCOPE  = 3'd1;
  localparam logic [2:0] STATUS_BOUNDS = 3'd2;
  localparam logic [2:0] STATUS_WIDE   = 3'd3;
  localparam logic [2:0] STATUS_ADDR   = 3'd4;

  localparam int unsigned ADDR_W = 18;
  localparam int unsigned WIDX_W = ADDR_W - 2;

  typedef enum logic [1:0] {
    FIELD_32,
    FIELD_24,
    FIELD_8,
    FIELD_BIT
  } field_kind_t;

  typedef enum logic {
    ST_IDLE,
    ST_MODIFY
  } state_t;

  typedef struct packed {
    logic [2:0]        status;
    logic              is_write;
    logic [WIDX_W-1:0] widx;
    logic [4:0]        shift;
    field_kind_t       kind;
    logic [31:0]       wr_value;
  } access_t;

endpackage

>>> design/twa_req_if.sv
// ----------------------------------------------------------------------------
// Typed word access request channel
// Valid/ready channel carrying one element read or write request.
// ----------------------------------------------------------------------------
interface twa_req_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic               is_array;
  logic               in_scope;
  logic [1:0]         elem_type;
  logic [9:0]         base_addr;
  logic [12:0]        elem_index;
  logic [13:0]        num_elements;
  logic signed [31:0] wr_value;

  modport source (
    output valid, func, is_array, in_scope, elem_type, base_addr, elem_index,
           num_elements, wr_value,
    input  ready
  );

  modport sink (
    input  valid, func, is_array, in_scope, elem_type, base_addr, elem_index,
           num_elements, wr_value,
    output ready
  );
endinterface

>>> design/twa_rsp_if.sv
// ----------------------------------------------------------------------------
// Typed word access response channel
// Valid/ready channel carrying the read value and status of one transaction.
// ----------------------------------------------------------------------------
interface twa_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] rd_value;
  logic [2:0]         status;

  modport source (
    output valid, rd_value, status,
    input  ready
  );

  modport sink (
    input  valid, rd_value, status,
    output ready
  );
endinterface

>>> design/typed_packed_word_access.sv
// ----------------------------------------------------------------------------
// Typed packed word access
// Reads and writes int, medium int, char and boolean elements in a word
// memory with big-endian byte lanes, using one read per transaction and a
// merged write-back for each write that passes its checks.
//
//   Channel  Dir  Contents
//   req      in   func, is_array, in_scope, elem_type, base_addr, elem_index,
//                 num_elements, wr_value
//   rsp      out  rd_value, status
//
// The word is read from the RAM in the cycle the request is accepted and is
// merged and written back in the next, since the RAM's read data is registered.
// A request is taken while the previous response waits, as long as that
// response is consumed in the same cycle. Reset is synchronous and clears the
// control state only; memory contents stay undefined until written.
// ----------------------------------------------------------------------------
module typed_packed_word_access #(
  parameter int MEM_WORDS = 256
) (
  input logic      clk,
  input logic      rst,
  twa_req_if.sink  req,
  twa_rsp_if.source rsp
);

  localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

  twa_pkg::state_t  state;
  twa_pkg::state_t  state_next;
  twa_pkg::access_t acc_in;
  twa_pkg::access_t acc_q;

  logic        accept;
  logic        ram_we;
  logic        rsp_load;
  logic [31:0] rdata;
  logic [31:0] mask;
  logic [31:0] field;
  logic [31:0] merged;
  logic [31:0] extracted;
  logic        rsp_valid;
  logic [31:0] rd_value;
  logic [2:0]  status;

  twa_decode #(
    .MEM_WORDS(MEM_WORDS)
  ) u_decode (
    .func        (req.func),
    .is_array    (req.is_array),
    .in_scope    (req.in_scope),
    .elem_type   (req.elem_type),
    .base_addr   (req.base_addr),
    .elem_index  (req.elem_index),
    .num_elements(req.num_elements),
    .wr_value    (req.wr_value),
    .acc         (acc_in)
  );

  twa_ram #(
    .WIDTH(32),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(acc_q.widx[AW-1:0]),
    .wdata(merged),
    .raddr(acc_in.widx[AW-1:0]),
    .rdata(rdata)
  );

  assign req.ready = (state == twa_pkg::ST_IDLE) && (!rsp_valid || rsp.ready);
  assign accept    = req.valid && req.ready;

  always_comb begin
    state_next = state;
    case (state)
      twa_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = twa_pkg::ST_MODIFY;
        end
      end
      twa_pkg::ST_MODIFY: begin
        state_next = twa_pkg::ST_IDLE;
      end
      default: begin
        state_next = twa_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_we   = 1'b0;
    rsp_load = 1'b0;
    case (state)
      twa_pkg::ST_MODIFY: begin
        rsp_load = 1'b1;
        ram_we   = acc_q.is_write && (acc_q.status == twa_pkg::STATUS_OK);
      end
      default: begin
        ram_we   = 1'b0;
        rsp_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= twa_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      acc_q <= acc_in;
    end
  end

  always_comb begin
    case (acc_q.kind)
      twa_pkg::FIELD_32:  mask = 32'hFFFF_FFFF;
      twa_pkg::FIELD_24:  mask = 32'h00FF_FFFF;
      twa_pkg::FIELD_8:   mask = 32'h0000_00FF;
      twa_pkg::FIELD_BIT: mask = 32'h0000_0001;
      default:            mask = 32'h0000_0000;
    endcase
  end

  assign field  = rdata >> acc_q.shift;
  assign merged = (rdata & ~(mask << acc_q.shift)) | ((acc_q.wr_value & mask) << acc_q.shift);

  always_comb begin
    case (acc_q.kind)
      twa_pkg::FIELD_32:  extracted = field;
      twa_pkg::FIELD_24:  extracted = {{8{field[23]}}, field[23:0]};
      twa_pkg::FIELD_8:   extracted = {{24{field[7]}}, field[7:0]};
      twa_pkg::FIELD_BIT: extracted = {31'd0, field[0]};
      default:            extracted = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (rsp_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      status <= acc_q.status;
      if (!acc_q.is_write && (acc_q.status == twa_pkg::STATUS_OK)) begin
        rd_value <= extracted;
      end else begin
        rd_value <= 32'd0;
      end
    end
  end

  assign rsp.valid    = rsp_valid;
  assign rsp.rd_value = rd_value;
  assign rsp.status   = status;

`ifndef SYNTHESIS
  a_accept_to_modify: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == twa_pkg::ST_MODIFY) && !rsp_valid)
    else $error("Accepted transaction did not enter the modify cycle.");

  a_modify_to_rsp: assert property (@(posedge clk) disable iff (rst)
    (state == twa_pkg::ST_MODIFY) |=> rsp_valid && (state == twa_pkg::ST_IDLE))
    else $error("Modify cycle did not produce a response.");

  a_rsp_only_idle: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (state == twa_pkg::ST_IDLE))
    else $error("Response pending while a transaction is in flight.");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (status != twa_pkg::STATUS_OK) |-> (rd_value == 32'd0))
    else $error("Failed transaction returned a nonzero value.");

  a_write_ok_only: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> $past(accept) &&
      ({1'b0, acc_q.widx} < (twa_pkg::WIDX_W + 1)'(MEM_WORDS)))
    else $error("Memory write without a valid accepted request.");
`endif

endmodule

>>> design/twa_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module twa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> design/twa_decode.sv
// ----------------------------------------------------------------------------
// Typed word access decoder
// Checks scope, bounds, value range and address of a request and works out
// the word index, bit shift and field kind of the element it touches.
// ----------------------------------------------------------------------------
module twa_decode #(
  parameter int MEM_WORDS = 256
) (
  input  logic               func,
  input  logic               is_array,
  input  logic               in_scope,
  input  logic [1:0]         elem_type,
  input  logic [9:0]         base_addr,
  input  logic [12:0]        elem_index,
  input  logic [13:0]        num_elements,
  input  logic signed [31:0] wr_value,
  output twa_pkg::access_t   acc
);

  logic                         bool_arr;
  logic [twa_pkg::ADDR_W-1:0]   elem_off;
  logic [twa_pkg::ADDR_W-1:0]   byte_addr;
  logic [1:0]                   off;
  logic                         misaligned;
  logic                         addr_bad;
  logic                         too_wide;
  logic [twa_pkg::WIDX_W-1:0]   widx;
  logic [4:0]                   shift;
  twa_pkg::field_kind_t         kind;
  logic [2:0]                   status;

  assign bool_arr = is_array && (elem_type == twa_pkg::TYPE_BOOL);

  always_comb begin
    elem_off = '0;
    if (is_array) begin
      if (elem_type inside {twa_pkg::TYPE_INT, twa_pkg::TYPE_MEDIUM}) begin
        elem_off = twa_pkg::ADDR_W'({elem_index, 2'b00});
      end else begin
        elem_off = twa_pkg::ADDR_W'(elem_index);
      end
    end
    if (bool_arr) begin
      byte_addr = twa_pkg::ADDR_W'(base_addr) + twa_pkg::ADDR_W'(elem_index[12:3]);
    end else begin
      byte_addr = twa_pkg::ADDR_W'(base_addr) + elem_off;
    end
  end

  assign off  = byte_addr[1:0];
  assign widx = byte_addr[twa_pkg::ADDR_W-1:2];

  always_comb begin
    misaligned = 1'b0;
    too_wide   = 1'b0;
    shift      = 5'd0;
    kind       = twa_pkg::FIELD_8;
    case (elem_type)
      twa_pkg::TYPE_INT: begin
        misaligned = (off != 2'd0);
        kind       = twa_pkg::FIELD_32;
      end
      twa_pkg::TYPE_MEDIUM: begin
        misaligned = off[1];
        too_wide   = !((wr_value[31:23] == '0) || (wr_value[31:23] == '1));
        shift      = {1'b0, ~off[0], 3'b000};
        kind       = twa_pkg::FIELD_24;
      end
      twa_pkg::TYPE_CHAR: begin
        too_wide = !((wr_value[31:7] == '0) || (wr_value[31:7] == '1));
        shift    = {~off, 3'b000};
      end
      twa_pkg::TYPE_BOOL: begin
        too_wide = !((wr_value == 32'sd0) || (wr_value == 32'sd1));
        if (bool_arr) begin
          shift = ~{off, elem_index[2:0]};
          kind  = twa_pkg::FIELD_BIT;
        end else begin
          shift = {~off, 3'b000};
        end
      end
      default: begin
        misaligned = 1'b1;
      end
    endcase
  end

  assign addr_bad = ({1'b0, widx} >= (twa_pkg::WIDX_W + 1)'(MEM_WORDS)) || misaligned;

  always_comb begin
    if (!in_scope) begin
      status = twa_pkg::STATUS_SCOPE;
    end else if (is_array && ({1'b0, elem_index} >= num_elements)) begin
      status = twa_pkg::STATUS_BOUNDS;
    end else if (func && too_wide) begin
      status = twa_pkg::STATUS_WIDE;
    end else if (addr_bad) begin
      status = twa_pkg::STATUS_ADDR;
    end else begin
      status = twa_pkg::STATUS_OK;
    end
  end

  always_comb begin
    acc.status   = status;
    acc.is_write = func;
    acc.widx     = widx;
    acc.shift    = shift;
    acc.kind     = kind;
    acc.wr_value = wr_value;
  end

endmodule
